/* rtl/core/byte_fifo_with_message_boundaries_top_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the message boundary byte FIFO
// Clocked property checks; empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef BYTE_FIFO_WITH_MESSAGE_BOUNDARIES_TOP_DEFINES_SVH
`define BYTE_FIFO_WITH_MESSAGE_BOUNDARIES_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// check gated off while reset is asserted
`define BFMB_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bfmb assertion failed");
// check that also holds through reset
`define BFMB_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("bfmb assertion failed");
`else
`define BFMB_ASSERT(label, clk, rst_n, prop)
`define BFMB_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

/* rtl/core/bfmb_pkg.sv */
// ----------------------------------------------------------------------------
// bfmb_pkg
// Types and constants shared by the message boundary byte FIFO.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bfmb_pkg;

    localparam int BYTE_DEPTH = 4096;
    localparam int MSG_DEPTH  = 256;
    localparam int BYTE_AW    = $clog2(BYTE_DEPTH);
    localparam int MSG_AW     = $clog2(MSG_DEPTH);
    localparam int FILL_W     = 13;
    localparam int CLOSED_W   = 9;
    localparam int LEN_W      = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam logic [FILL_W-1:0]   BYTE_DEPTH_C = FILL_W'(BYTE_DEPTH);
    localparam logic [CLOSED_W-1:0] MSG_DEPTH_C  = CLOSED_W'(MSG_DEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKING = 1'b1;

    localparam logic [CFG_DATA_W-1:0] CAPACITY_RST = 13'd4096;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_CLOSE = 2'd1,
        OP_READ  = 2'd2
    } op_e_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_DROPPED   = 3'd1,
        ST_FULL_ERR  = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_EMPTY_MSG = 3'd4,
        ST_LEN_FULL  = 3'd5
    } status_e_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] write_data;
    } in_item_t;

    typedef struct packed {
        logic [2:0]          status;
        logic [7:0]          read_data;
        logic                end_of_message;
        logic [FILL_W-1:0]   fill_count;
        logic [CLOSED_W-1:0] closed_messages;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic load;   // capture the accepted item, store reads are in flight
        logic exec;   // apply the operation and load the result register
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;  // result register can take a new result this cycle
    } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/core/bfmb_ram.sv */
// ----------------------------------------------------------------------------
// bfmb_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfmb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

/* rtl/core/bfmb_ctrl.sv */
// ----------------------------------------------------------------------------
// bfmb_ctrl
// Sequencer: accept an item, then apply it once the result register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfmb_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire bfmb_pkg::dp_stat_t stat,
    output bfmb_pkg::dp_cmd_t      cmd
);

    bfmb_pkg::state_t state_reg;
    bfmb_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bfmb_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        case (state_reg)
            bfmb_pkg::S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = bfmb_pkg::S_EXEC;
                end
            end
            bfmb_pkg::S_EXEC: begin
                // hold until the previous result has been taken
                cmd.exec = stat.out_free;
                if (stat.out_free) begin
                    state_next = bfmb_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = bfmb_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/bfmb_dp.sv */
// ----------------------------------------------------------------------------
// bfmb_dp
// Datapath: byte and length stores, pointers, counts, config, result reg.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "byte_fifo_with_message_boundaries_top_defines.svh"

module bfmb_dp (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire bfmb_pkg::dp_cmd_t                   cmd,
    output bfmb_pkg::dp_stat_t                       stat,
    input  wire bfmb_pkg::in_item_t                  s_payload,
    input  wire logic                                cfg_we,
    input  wire logic [bfmb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [bfmb_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output bfmb_pkg::out_item_t                      m_payload
);

    localparam int BAW = bfmb_pkg::BYTE_AW;
    localparam int MAW = bfmb_pkg::MSG_AW;
    localparam int FW  = bfmb_pkg::FILL_W;
    localparam int CW  = bfmb_pkg::CLOSED_W;
    localparam int LW  = bfmb_pkg::LEN_W;

    // config
    logic [bfmb_pkg::CFG_DATA_W-1:0] capacity_reg;
    logic                            blocking_reg;

    // captured item
    bfmb_pkg::in_item_t item_reg;

    // FIFO state
    logic [BAW-1:0] bhead_reg, bhead_next;
    logic [BAW-1:0] btail_reg, btail_next;
    logic [FW-1:0]  bcount_reg, bcount_next;
    logic [MAW-1:0] lhead_reg, lhead_next;
    logic [MAW-1:0] ltail_reg, ltail_next;
    logic [CW-1:0]  lcount_reg, lcount_next;
    logic [LW-1:0]  open_reg, open_next;

    // result register
    logic                m_valid_reg, m_valid_next;
    bfmb_pkg::out_item_t m_payload_reg, m_payload_next;

    // store ports
    logic           b_we;
    logic [7:0]     b_rdata;
    logic           l_we;
    logic [MAW-1:0] l_waddr;
    logic [LW-1:0]  l_wdata;
    logic [LW-1:0]  l_rdata;

    logic [FW-1:0]  limit;
    logic           full;
    logic [LW-1:0]  front_dec;

    function automatic logic [BAW-1:0] binc(input logic [BAW-1:0] p);
        binc = (p == BAW'(bfmb_pkg::BYTE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [MAW-1:0] linc(input logic [MAW-1:0] p);
        linc = (p == MAW'(bfmb_pkg::MSG_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    bfmb_ram #(.WIDTH(8), .DEPTH(bfmb_pkg::BYTE_DEPTH)) u_byte_ram (
        .aclk    (aclk),
        .wr_en   (b_we),
        .wr_addr (btail_reg),
        .wr_data (item_reg.write_data),
        .rd_addr (bhead_reg),
        .rd_data (b_rdata)
    );

    bfmb_ram #(.WIDTH(LW), .DEPTH(bfmb_pkg::MSG_DEPTH)) u_len_ram (
        .aclk    (aclk),
        .wr_en   (l_we),
        .wr_addr (l_waddr),
        .wr_data (l_wdata),
        .rd_addr (lhead_reg),
        .rd_data (l_rdata)
    );

    assign limit = (capacity_reg < bfmb_pkg::BYTE_DEPTH_C) ? capacity_reg
                                                           : bfmb_pkg::BYTE_DEPTH_C;
    assign full      = (bcount_reg >= limit);
    assign front_dec = l_rdata - 1'b1;

    assign stat.out_free = !m_valid_reg || m_ready;

    always_comb begin
        bhead_next     = bhead_reg;
        btail_next     = btail_reg;
        bcount_next    = bcount_reg;
        lhead_next     = lhead_reg;
        ltail_next     = ltail_reg;
        lcount_next    = lcount_reg;
        open_next      = open_reg;
        b_we           = 1'b0;
        l_we           = 1'b0;
        l_waddr        = ltail_reg;
        l_wdata        = open_reg;
        m_payload_next = m_payload_reg;
        m_valid_next   = m_valid_reg && !m_ready;

        if (cmd.exec) begin
            m_payload_next        = '0;
            m_payload_next.status = bfmb_pkg::ST_OK;
            case (item_reg.opcode)
                bfmb_pkg::OP_WRITE: begin
                    if (full) begin
                        m_payload_next.status = blocking_reg ? bfmb_pkg::ST_FULL_ERR
                                                             : bfmb_pkg::ST_DROPPED;
                    end else begin
                        b_we        = 1'b1;
                        btail_next  = binc(btail_reg);
                        bcount_next = bcount_reg + 1'b1;
                        open_next   = open_reg + 1'b1;
                    end
                end
                bfmb_pkg::OP_CLOSE: begin
                    if (lcount_reg >= bfmb_pkg::MSG_DEPTH_C) begin
                        m_payload_next.status = bfmb_pkg::ST_LEN_FULL;
                    end else begin
                        l_we        = 1'b1;
                        ltail_next  = linc(ltail_reg);
                        lcount_next = lcount_reg + 1'b1;
                        open_next   = '0;
                    end
                end
                bfmb_pkg::OP_READ: begin
                    if (lcount_reg != '0 && l_rdata == '0) begin
                        // empty message at the front
                        lhead_next  = linc(lhead_reg);
                        lcount_next = lcount_reg - 1'b1;
                        m_payload_next.status         = bfmb_pkg::ST_EMPTY_MSG;
                        m_payload_next.end_of_message = 1'b1;
                    end else if (bcount_reg == '0) begin
                        m_payload_next.status = bfmb_pkg::ST_EMPTY;
                    end else begin
                        m_payload_next.read_data = b_rdata;
                        bhead_next  = binc(bhead_reg);
                        bcount_next = bcount_reg - 1'b1;
                        if (lcount_reg != '0) begin
                            if (front_dec == '0) begin
                                lhead_next  = linc(lhead_reg);
                                lcount_next = lcount_reg - 1'b1;
                                m_payload_next.end_of_message = 1'b1;
                            end else begin
                                l_we    = 1'b1;
                                l_waddr = lhead_reg;
                                l_wdata = front_dec;
                            end
                        end else if (open_reg != '0) begin
                            open_next = open_reg - 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
            m_payload_next.fill_count      = bcount_next;
            m_payload_next.closed_messages = lcount_next;
            m_valid_next                   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= bfmb_pkg::CAPACITY_RST;
            blocking_reg <= 1'b1;
            bhead_reg    <= '0;
            btail_reg    <= '0;
            bcount_reg   <= '0;
            lhead_reg    <= '0;
            ltail_reg    <= '0;
            lcount_reg   <= '0;
            open_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    bfmb_pkg::CFG_CAPACITY: capacity_reg <= cfg_data;
                    bfmb_pkg::CFG_BLOCKING: blocking_reg <= cfg_data[0];
                    default: begin
                    end
                endcase
            end
            bhead_reg   <= bhead_next;
            btail_reg   <= btail_next;
            bcount_reg  <= bcount_next;
            lhead_reg   <= lhead_next;
            ltail_reg   <= ltail_next;
            lcount_reg  <= lcount_next;
            open_reg    <= open_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_payload;
        end
        m_payload_reg <= m_payload_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    `BFMB_ASSERT(a_bcount_bound, aclk, aresetn, bcount_reg <= bfmb_pkg::BYTE_DEPTH_C)
    `BFMB_ASSERT(a_lcount_bound, aclk, aresetn, lcount_reg <= bfmb_pkg::MSG_DEPTH_C)
    `BFMB_ASSERT(a_write_grows, aclk, aresetn, (cmd.exec && item_reg.opcode == bfmb_pkg::OP_WRITE && !full) |=> (bcount_reg == $past(bcount_reg) + 1'b1))
    `BFMB_ASSERT(a_emptymsg_eom, aclk, aresetn, (m_valid_reg && m_payload_reg.status == bfmb_pkg::ST_EMPTY_MSG) |-> m_payload_reg.end_of_message)
    `BFMB_ASSERT(a_no_overwrite, aclk, aresetn, (m_valid_reg && !m_ready) |-> !cmd.exec)

endmodule

`default_nettype wire

/* rtl/core/byte_fifo_with_message_boundaries_top.sv */
// ----------------------------------------------------------------------------
// byte_fifo_with_message_boundaries_top
// Byte FIFO that keeps message boundaries via a queue of closed lengths.
// ----------------------------------------------------------------------------
// Usage:
//  - s_ channel: one operation per transfer (write byte, close message,
//    read byte); opcode three is a no-op.
//  - m_ channel: exactly one result transfer per operation, in order:
//    status, popped byte, end-of-message flag, fill count, queued lengths.
//  - cfg channel: capacity (index 0) and blocking mode (index 1); always
//    ready; the user must write it only while the block is idle, as the block leaves this to the user.
//  - Timing: the accepted item is first captured in the item register,
//    then applied and loaded into the output register once that is free.
//  - Ordering: no new operation is taken until the previous one is applied;
//    the stores are read with a registered port at the head pointers.
//  - Receiver stall: the result is held in the output register; one more
//    operation is taken and waits until that result has gone.
//  - Reset: pointers, counts and config return to their defaults at once;
//    store contents are not cleared, the counts guard every read, so no
//    clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module byte_fifo_with_message_boundaries_top (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // operation input
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire bfmb_pkg::in_item_t                  s_payload,
    // result output
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output bfmb_pkg::out_item_t                      m_payload,
    // register writes
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [bfmb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [bfmb_pkg::CFG_DATA_W-1:0]     cfg_data
);

    bfmb_pkg::dp_cmd_t  cmd;
    bfmb_pkg::dp_stat_t stat;

    // register writes never stall
    assign cfg_ready = 1'b1;

    bfmb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bfmb_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_payload (s_payload),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

`default_nettype wire

/* tb/message_fifo_tb_pkg.sv */
// ----------------------------------------------------------------------------
// message_fifo_tb_pkg
// Scoreboard for the message boundary byte FIFO: a cycle-free model of the
// byte store and length queue that predicts each result and checks it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package message_fifo_tb_pkg;

    import bfmb_pkg::*;

    // opcode three has no name in the block's package; it is a no-op
    localparam logic [1:0] OP_NOP = 2'd3;

    class message_fifo_scoreboard;

        logic [7:0]       byte_mem [BYTE_DEPTH];
        logic [LEN_W-1:0] msg_len  [MSG_DEPTH];
        int unsigned      byte_rd_ptr;
        int unsigned      byte_wr_ptr;
        int unsigned      byte_fill;
        int unsigned      len_rd_ptr;
        int unsigned      len_wr_ptr;
        int unsigned      len_fill;
        int unsigned      open_bytes;
        int unsigned      capacity;
        bit               blocking;

        out_item_t        pending_results [$];
        int unsigned      results_checked;
        int unsigned      errors;
        int unsigned      status_seen [8];
        int unsigned      boundaries_seen;
        int unsigned      peak_fill;
        int unsigned      peak_queued;

        function new();
            capacity = CAPACITY_RST;
            blocking = 1'b1;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
            case (index)
                CFG_CAPACITY: capacity = value;
                CFG_BLOCKING: blocking = value[0];
                default: ;
            endcase
        endfunction

        // pop the front length and flag the boundary
        function void retire_front_length(ref out_item_t res);
            len_rd_ptr         = (len_rd_ptr + 1) % MSG_DEPTH;
            len_fill           = len_fill - 1;
            res.end_of_message = 1'b1;
        endfunction

        function out_item_t predict_outcome(in_item_t op);
            out_item_t   res;
            int unsigned limit;
            res        = '0;
            res.status = ST_OK;
            limit      = (capacity < BYTE_DEPTH) ? capacity : BYTE_DEPTH;
            case (op.opcode)
                OP_WRITE: begin
                    if (byte_fill >= limit) begin
                        res.status = blocking ? ST_FULL_ERR : ST_DROPPED;
                    end else begin
                        byte_mem[byte_wr_ptr] = op.write_data;
                        byte_wr_ptr           = (byte_wr_ptr + 1) % BYTE_DEPTH;
                        byte_fill++;
                        open_bytes++;
                    end
                end
                OP_CLOSE: begin
                    if (len_fill >= MSG_DEPTH) begin
                        res.status = ST_LEN_FULL;
                    end else begin
                        msg_len[len_wr_ptr] = LEN_W'(open_bytes);
                        len_wr_ptr          = (len_wr_ptr + 1) % MSG_DEPTH;
                        len_fill++;
                        open_bytes = 0;
                    end
                end
                OP_READ: begin
                    if (len_fill != 0 && msg_len[len_rd_ptr] == '0) begin
                        res.status = ST_EMPTY_MSG;
                        retire_front_length(res);
                    end else if (byte_fill == 0) begin
                        res.status = ST_EMPTY;
                    end else begin
                        res.read_data = byte_mem[byte_rd_ptr];
                        byte_rd_ptr   = (byte_rd_ptr + 1) % BYTE_DEPTH;
                        byte_fill--;
                        if (len_fill != 0) begin
                            msg_len[len_rd_ptr] = msg_len[len_rd_ptr] - 1'b1;
                            if (msg_len[len_rd_ptr] == '0)
                                retire_front_length(res);
                        end else if (open_bytes != 0) begin
                            open_bytes--;
                        end
                    end
                end
                default: ;
            endcase
            res.fill_count      = FILL_W'(byte_fill);
            res.closed_messages = CLOSED_W'(len_fill);
            if (byte_fill > peak_fill)
                peak_fill = byte_fill;
            if (len_fill > peak_queued)
                peak_queued = len_fill;
            status_seen[res.status]++;
            if (res.end_of_message)
                boundaries_seen++;
            return res;
        endfunction

        function void note_operation(in_item_t op);
            pending_results.push_back(predict_outcome(op));
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $realtime, got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            results_checked++;
            compare_field("status", 16'(want.status), 16'(got.status));
            compare_field("read_data", 16'(want.read_data), 16'(got.read_data));
            compare_field("end_of_message", 16'(want.end_of_message), 16'(got.end_of_message));
            compare_field("fill_count", 16'(want.fill_count), 16'(got.fill_count));
            compare_field("closed_messages", 16'(want.closed_messages),
                          16'(got.closed_messages));
        endfunction

        function void report_leftovers();
            if (pending_results.size() != 0) begin
                $display("%0t: %0d results never arrived, expected %0d more, got none",
                         $realtime, pending_results.size(), pending_results.size());
                errors++;
            end
        endfunction

    endclass

endpackage

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the message boundary byte FIFO. Directed and
// random operation streams under several capacity and blocking settings,
// with bursty input, a stalling receiver and scoreboard checking.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import bfmb_pkg::*;
    import message_fifo_tb_pkg::*;

    localparam int CLK_PERIOD      = 4;
    localparam int RESET_CYCLES    = 4;
    localparam int HOLD_OFF_CYCLES = 300;   // long receiver hold-off
    localparam int STALL_LIMIT     = 3000;  // cycles with no transfer at all
    localparam int SETTLE_CYCLES   = 8;     // margin after the last result is checked
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_OPS       = 120;
    // capacity per random phase; 8191 is above the store depth
    localparam int unsigned PHASE_CAPS [RANDOM_PHASES] = '{4096, 1, 2, 7, 8191, 16, 33, 3};

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    in_item_t  s_payload = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    out_item_t m_payload;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    message_fifo_scoreboard tracker = new();

    int unsigned ops_sent;      // operation transfers completed by the sender
    int unsigned burst_left;    // transfers left in the current sender burst
    int unsigned hold_requests; // hold-offs asked for by the stimulus
    int unsigned hold_served;   // hold-offs started by the receiver
    int unsigned hold_left;
    int unsigned rx_cycle;

    byte_fifo_with_message_boundaries_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Monitor. Everything is sampled straight after the rising edge, so the
    // values seen are those the block saw at that edge. Register writes are
    // applied first: an operation transfer after one sees the new setting.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                tracker.set_register(cfg_index, cfg_data);
            if (s_valid && s_ready)
                tracker.note_operation(s_payload);
            if (m_valid && m_ready)
                tracker.check_result(m_payload);
        end
    end

    // ------------------------------------------------------------------------
    // Receiver. Cycles through four stall patterns (always ready, coin toss,
    // mostly ready, ready on multiples of three), picked from the cycle count.
    // A hold-off request from the stimulus drops ready for a long stretch so
    // the block backs up and stalls its input while the sender keeps offering.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = HOLD_OFF_CYCLES - 1;
            m_ready <= 1'b0;
        end else begin
            case ((rx_cycle / 97) % 4)
                0:       m_ready <= 1'b1;
                1:       m_ready <= 1'($urandom_range(0, 1));
                2:       m_ready <= ($urandom_range(0, 7) != 0);
                default: m_ready <= (rx_cycle % 3 == 0);
            endcase
        end
        rx_cycle++;
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run if no channel moves for too long.
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: timeout, no transfer for %0d cycles, %0d results outstanding",
                 $realtime, quiet, tracker.pending_results.size());
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sender: one operation transfer. Transfers come in bursts of random
    // length; between bursts valid drops for a random gap. Within a burst
    // valid stays high from one transfer to the next.
    // ------------------------------------------------------------------------
    task automatic send_op(input logic [1:0] opcode, input logic [7:0] data);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(32, 96)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(1, 4);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        burst_left--;
        s_valid   <= 1'b1;
        s_payload <= '{opcode: opcode, write_data: data};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        ops_sent++;
    endtask

    // Stop offering and wait for every result to come back.
    task automatic wait_drained();
        s_valid    <= 1'b0;
        burst_left = 0;
        while (tracker.results_checked < ops_sent) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Register write, only ever with the block idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input int unsigned value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly complete messages and read bursts, with some single random ops
    // (the no-op opcode among them) as noise.
    task automatic run_random_phase(input int unsigned n_ops);
        int unsigned issued;
        int unsigned run_len;
        int unsigned choice;
        issued = 0;
        while (issued < n_ops) begin
            choice = $urandom_range(0, 99);
            if (choice < 45) begin
                run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1)
                                                      : $urandom_range(2, 12);
                repeat (run_len) send_op(OP_WRITE, 8'($urandom));
                send_op(OP_CLOSE, 8'($urandom));
                issued += run_len + 1;
            end else if (choice < 88) begin
                run_len = $urandom_range(1, 14);
                repeat (run_len) send_op(OP_READ, 8'($urandom));
                issued += run_len;
            end else begin
                send_op(2'($urandom_range(0, 3)), 8'($urandom));
                issued++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int unsigned phase;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: small store, error mode. Empty read, no-op, a two byte
        // message, a zero-length message, write into a full store, reads
        // across both boundaries, a byte charged to the open message.
        write_reg(CFG_CAPACITY, 3);
        write_reg(CFG_BLOCKING, 1);
        send_op(OP_READ, 8'h00);   // nothing stored: empty
        send_op(OP_NOP, 8'hFF);
        send_op(OP_WRITE, 8'h00);
        send_op(OP_WRITE, 8'hFF);
        send_op(OP_CLOSE, 8'h00);
        send_op(OP_CLOSE, 8'hFF);  // zero-length message
        send_op(OP_WRITE, 8'hA5);
        send_op(OP_WRITE, 8'h5A);  // store full: error
        send_op(OP_READ, 8'h00);
        send_op(OP_READ, 8'h00);   // end of first message
        send_op(OP_READ, 8'h00);   // empty message at the front
        send_op(OP_READ, 8'h00);   // byte from the open message
        send_op(OP_READ, 8'h00);   // empty
        send_op(OP_CLOSE, 8'h00);  // open count already back at zero
        send_op(OP_READ, 8'h00);
        send_op(OP_READ, 8'h00);
        // same store in silent-drop mode
        write_reg(CFG_BLOCKING, 0);
        send_op(OP_WRITE, 8'h3C);
        send_op(OP_WRITE, 8'hC3);
        send_op(OP_WRITE, 8'h81);
        send_op(OP_WRITE, 8'h7E);  // dropped
        send_op(OP_CLOSE, 8'h00);
        repeat (4) send_op(OP_READ, 8'h00);

        // Random phases across capacities, both modes. Two phases start
        // with a long receiver hold-off so the block backs up.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            write_reg(CFG_CAPACITY, PHASE_CAPS[phase]);
            write_reg(CFG_BLOCKING, phase % 2);
            if (phase == 0 || phase == 4)
                hold_requests++;
            run_random_phase(PHASE_OPS);
        end

        // Capacity zero refuses every write; then fill the length queue with
        // empty messages, overflow it once and read it all back.
        write_reg(CFG_CAPACITY, 0);
        send_op(OP_WRITE, 8'hFF);
        send_op(OP_WRITE, 8'h00);
        repeat (MSG_DEPTH + 1) send_op(OP_CLOSE, 8'($urandom));
        repeat (MSG_DEPTH + 2) send_op(OP_READ, 8'($urandom));

        wait_drained();
        tracker.report_leftovers();

        $display("covered %0d operations: %0d ok, %0d dropped, %0d full errors, %0d empty,",
                 ops_sent, tracker.status_seen[ST_OK], tracker.status_seen[ST_DROPPED],
                 tracker.status_seen[ST_FULL_ERR], tracker.status_seen[ST_EMPTY]);
        $display("%0d empty messages, %0d length queue overflows, %0d boundaries,",
                 tracker.status_seen[ST_EMPTY_MSG], tracker.status_seen[ST_LEN_FULL],
                 tracker.boundaries_seen);
        $display("peak %0d bytes, %0d lengths, %0d errors",
                 tracker.peak_fill, tracker.peak_queued, tracker.errors);
        if (tracker.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
